// ===== rtl/core/m3i_pkg.sv =====
`timescale 1ns / 1ps
// Package: widths, cofactor operand table and queue entry type for the 3x3 inverse
package m3i_pkg;

    localparam int W    = 32;          // element width, signed Q16.16
    localparam int F    = 16;          // fraction bits
    localparam int CW   = 2 * W + 1;   // signed cofactor
    localparam int CMW  = 2 * W;       // cofactor magnitude
    localparam int PW   = 2 * W + 1;   // determinant partial product
    localparam int DETW = 3 * W + 1;   // signed determinant
    localparam int DMW  = 3 * W;       // determinant magnitude
    localparam int TW   = DMW + W;     // divider remainder width

    localparam int QUEUE_DEPTH_DEF = 4;

    // cofactor i = a[op0]*a[op1] - a[op2]*a[op3], elements numbered row then column
    localparam int unsigned CF_OP [9][4] = '{
        '{4, 8, 5, 7},
        '{5, 6, 3, 8},
        '{3, 7, 4, 6},
        '{2, 7, 1, 8},
        '{0, 8, 2, 6},
        '{1, 6, 0, 7},
        '{1, 5, 2, 4},
        '{2, 3, 0, 5},
        '{0, 4, 1, 3}
    };

    typedef logic [8:0][W-1:0] t_mat;

    // adjugate magnitudes in output order, result signs, |det| and singular flag
    typedef struct packed {
        logic [8:0][CMW-1:0] mag;
        logic [8:0]          neg;
        logic [DMW-1:0]      dmag;
        logic                sing;
    } t_qent;

endpackage

// ===== rtl/core/m3i_front.sv =====
`timescale 1ns / 1ps
// Front end: cofactors, determinant and singular classification
module m3i_front
    import m3i_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_mat  i_mat,
    output logic  o_push,
    output t_qent o_ent,
    input  logic  i_full
);

    logic en;
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf;

    logic [17:0][2*W-1:0] r_prod;
    logic [2:0][W-1:0]    r_row_a, r_row_b;
    logic [8:0][CW-1:0]   r_cof_b, r_cof_c, r_cof_d, r_cof_e;
    logic [2:0][PW-1:0]   r_pl, r_ph;
    logic [2:0][DETW-1:0] r_term;
    logic [DETW-1:0]      r_det;
    t_qent                r_ent;
    t_qent                n_ent;
    logic [DETW-1:0]      w_dabs;

    assign en      = !(r_vf && i_full);
    assign o_stall = !en;
    assign o_push  = r_vf && !i_full;
    assign o_ent   = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
        end
    end

    for (genvar i = 0; i < 9; i++) begin : g_cof
        logic signed [2*W-1:0] w_p0, w_p1;
        assign w_p0 = $signed(i_mat[CF_OP[i][0]]) * $signed(i_mat[CF_OP[i][1]]);
        assign w_p1 = $signed(i_mat[CF_OP[i][2]]) * $signed(i_mat[CF_OP[i][3]]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_prod[2*i]   <= w_p0;
                r_prod[2*i+1] <= w_p1;
                r_cof_b[i]    <= CW'($signed(r_prod[2*i])) - CW'($signed(r_prod[2*i+1]));
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        logic signed [PW-1:0] w_pl, w_ph;
        assign w_pl = $signed(r_row_b[j]) * $signed({1'b0, r_cof_b[j][W-1:0]});
        assign w_ph = $signed(r_row_b[j]) * $signed(r_cof_b[j][CW-1:W]);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_row_a[j] <= i_mat[j];
                r_row_b[j] <= r_row_a[j];
                r_pl[j]    <= w_pl;
                r_ph[j]    <= w_ph;
                r_term[j]  <= (DETW'($signed(r_ph[j])) <<< W) + DETW'($signed(r_pl[j]));
            end
        end
    end

    assign w_dabs = r_det[DETW-1] ? -r_det : r_det;

    always_comb begin
        n_ent      = '0;
        n_ent.dmag = w_dabs[DMW-1:0];
        n_ent.sing = (r_det == '0);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                logic [CW-1:0] c;
                logic [CW-1:0] cabs;
                c    = r_cof_e[j*3+i];
                cabs = c[CW-1] ? -c : c;
                n_ent.mag[i*3+j] = cabs[CMW-1:0];
                n_ent.neg[i*3+j] = c[CW-1] ^ r_det[DETW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cof_c <= r_cof_b;
            r_cof_d <= r_cof_c;
            r_cof_e <= r_cof_d;
            r_det   <= r_term[0] + r_term[1] + r_term[2];
            r_ent   <= n_ent;
        end
    end

endmodule

// ===== rtl/core/m3i_queue.sv =====
`timescale 1ns / 1ps
// Short queue between the front and back ends
module m3i_queue
    import m3i_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    output logic  o_full,
    input  logic  i_pop,
    output t_qent o_ent,
    output logic  o_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_qent           r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd, n_wr, n_rd;
    logic [CNTW-1:0] r_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_ent   = r_mem[r_rd];
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= n_wr;
            if (i_pop) r_rd <= n_rd;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_ent;
    end

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH)) else $error("queue count overflow");
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");

endmodule

// ===== rtl/core/m3i_lane.sv =====
`timescale 1ns / 1ps
// One divider lane: pipelined restoring division, rounding and saturation
module m3i_lane
    import m3i_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [CMW-1:0] i_mag,
    input  logic           i_neg,
    input  logic [DMW-1:0] i_dmag,
    input  logic           i_zero,
    output logic [W-1:0]   o_res
);

    logic [TW-1:0]  r_rem [W+1];
    logic [DMW-1:0] r_d   [W+1];
    logic [W-1:0]   r_q   [W+1];
    logic [W:0]     r_ng, r_bg;
    logic [W-1:0]   r_res, n_res;
    logic [TW:0]    w_big;
    logic           w_rnd;
    logic [W:0]     w_qr, w_nq, w_lim;

    // quotient of 2^W or more saturates whatever the rounding
    assign w_big = {1'b0, TW'(i_mag) << (2 * F)} - ({1'b0, TW'(i_dmag)} << W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= TW'(i_mag) << (2 * F);
            r_d[0]   <= i_dmag;
            r_q[0]   <= '0;
            r_ng[0]  <= i_neg;
            r_bg[0]  <= !w_big[TW];
        end
    end

    for (genvar s = 1; s <= W; s++) begin : g_step
        localparam int K = W - s;
        logic [TW:0] w_diff;
        assign w_diff = {1'b0, r_rem[s-1]} - ({1'b0, TW'(r_d[s-1])} << K);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_diff[TW] ? r_rem[s-1] : w_diff[TW-1:0];
                r_q[s]   <= r_q[s-1] | (w_diff[TW] ? W'(0) : (W'(1) << K));
                r_d[s]   <= r_d[s-1];
                r_ng[s]  <= r_ng[s-1];
                r_bg[s]  <= r_bg[s-1];
            end
        end
    end

    assign w_rnd = {r_rem[W][DMW-1:0], 1'b0} >= {1'b0, r_d[W]};
    assign w_qr  = {1'b0, r_q[W]} + (W+1)'(w_rnd);
    assign w_nq  = -w_qr;
    assign w_lim = (W+1)'(1) << (W - 1);

    always_comb begin
        if (i_zero) begin
            n_res = '0;
        end else if (!r_ng[W]) begin
            n_res = (r_bg[W] || w_qr >= w_lim) ? {1'b0, {(W-1){1'b1}}} : w_qr[W-1:0];
        end else begin
            n_res = (r_bg[W] || w_qr > w_lim) ? {1'b1, {(W-1){1'b0}}} : w_nq[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== rtl/core/m3i_back.sv =====
`timescale 1ns / 1ps
// Back end: nine divider lanes sharing one valid chain and one singular chain
module m3i_back
    import m3i_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    output logic              o_pop,
    input  t_qent             i_ent,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [8:0][W-1:0] o_res,
    output logic              o_sing
);

    localparam int NST = W + 2;

    logic             en;
    logic [NST-1:0]   r_v, r_sg;

    assign en      = !(r_v[NST-1] && i_stall);
    assign o_pop   = en && !i_empty;
    assign o_valid = r_v[NST-1];
    assign o_sing  = r_sg[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_sg <= {r_sg[NST-2:0], i_ent.sing};
    end

    for (genvar g = 0; g < 9; g++) begin : g_lane
        m3i_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_mag  (i_ent.mag[g]),
            .i_neg  (i_ent.neg[g]),
            .i_dmag (i_ent.dmag),
            .i_zero (r_sg[NST-2]),
            .o_res  (o_res[g])
        );
    end

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sing |-> o_res == '0) else $error("singular item with nonzero result");

endmodule

// ===== rtl/core/matrix3x3_inverse_adjugate_top.sv =====
`timescale 1ns / 1ps
// Top level: 3x3 Q16.16 matrix inverse by adjugate
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_stall    i_a00 .. i_a22
//  output   out        o_valid / i_stall    o_inv00 .. o_inv22, o_singular
//
// One item per cycle unless stalled; path: 6 front stages, the queue, W+2 back stages.
// The back end runs one restoring division step per stage in each of nine lanes.
// Reset is synchronous, clears valids, queue pointers and queue count only.
// An output stall holds the back end; the front keeps accepting until the queue fills.
module matrix3x3_inverse_adjugate_top
    import m3i_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [W-1:0] i_a00,
    input  logic [W-1:0] i_a01,
    input  logic [W-1:0] i_a02,
    input  logic [W-1:0] i_a10,
    input  logic [W-1:0] i_a11,
    input  logic [W-1:0] i_a12,
    input  logic [W-1:0] i_a20,
    input  logic [W-1:0] i_a21,
    input  logic [W-1:0] i_a22,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [W-1:0] o_inv00,
    output logic [W-1:0] o_inv01,
    output logic [W-1:0] o_inv02,
    output logic [W-1:0] o_inv10,
    output logic [W-1:0] o_inv11,
    output logic [W-1:0] o_inv12,
    output logic [W-1:0] o_inv20,
    output logic [W-1:0] o_inv21,
    output logic [W-1:0] o_inv22,
    output logic         o_singular
);

    t_mat              w_mat;
    t_qent             w_push_ent, w_pop_ent;
    logic              w_push, w_full, w_pop, w_empty;
    logic [8:0][W-1:0] w_res;

    assign w_mat = {i_a22, i_a21, i_a20, i_a12, i_a11, i_a10, i_a02, i_a01, i_a00};

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mat   (w_mat),
        .o_push  (w_push),
        .o_ent   (w_push_ent),
        .i_full  (w_full)
    );

    m3i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_ent   (w_pop_ent),
        .o_empty (w_empty)
    );

    m3i_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_ent   (w_pop_ent),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_res),
        .o_sing  (o_singular)
    );

    assign o_inv00 = w_res[0];
    assign o_inv01 = w_res[1];
    assign o_inv02 = w_res[2];
    assign o_inv10 = w_res[3];
    assign o_inv11 = w_res[4];
    assign o_inv12 = w_res[5];
    assign o_inv20 = w_res[6];
    assign o_inv21 = w_res[7];
    assign o_inv22 = w_res[8];

endmodule
